// ===== hdl/bcdalu_pkg.sv =====
// ----------------------------------------------------------------------------
// bcdalu_pkg
// Types and constants shared by the BCD/binary add-subtract unit.
// ----------------------------------------------------------------------------
package bcdalu_pkg;

  localparam int unsigned DATA_W   = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 9;

  // status word bit positions
  localparam int unsigned ST_C = 0;
  localparam int unsigned ST_Z = 1;
  localparam int unsigned ST_D = 3;
  localparam int unsigned ST_V = 6;
  localparam int unsigned ST_N = 7;

  // status bits carried through unchanged
  localparam logic [STATUS_W-1:0] ST_PASS_MASK = 9'h13c;

  typedef struct packed {
    logic [DATA_W-1:0]   operand_a;
    logic [DATA_W-1:0]   operand_b;
    logic [STATUS_W-1:0] status_in;
    logic                subtract;
    logic                wide;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0]   result;
    logic [STATUS_W-1:0] status_out;
  } out_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   sum;
    logic [STATUS_W-1:0] status;
  } step_res_t;

endpackage

// ===== hdl/bcdalu_byte_step.sv =====
// ----------------------------------------------------------------------------
// bcdalu_byte_step
// One byte of add/subtract, binary or nibble-corrected BCD, with flags.
// ----------------------------------------------------------------------------
module bcdalu_byte_step (
  input  logic [7:0]              a,
  input  logic [7:0]              b,
  input  logic [8:0]              st,
  input  logic                    sub,
  output bcdalu_pkg::step_res_t   res
);

  logic [7:0] bb;
  logic [8:0] bin_sum;
  logic [4:0] lo_raw;
  logic [4:0] lo_adj;
  logic [8:0] dec_raw;
  logic [9:0] dec_sum;
  logic [9:0] fin;
  logic       decimal;
  logic       ov;
  logic       carry;

  always_comb begin
    bb      = sub ? ~b : b;
    decimal = st[bcdalu_pkg::ST_D];
    bin_sum = {1'b0, a} + {1'b0, bb} + {8'd0, st[bcdalu_pkg::ST_C]};

    lo_raw = {1'b0, a[3:0]} + {1'b0, bb[3:0]} + {4'd0, st[bcdalu_pkg::ST_C]};
    lo_adj = lo_raw;
    if (sub) begin
      if (!lo_raw[4]) begin
        lo_adj = {1'b0, lo_raw[3:0] - 4'h6};
      end
    end else if (lo_raw >= 5'h0a) begin
      lo_adj = (lo_raw - 5'h0a) | 5'h10;
    end

    dec_raw = {1'b0, a[7:4], 4'h0} + {1'b0, bb[7:4], 4'h0} + {4'd0, lo_adj};
    dec_sum = {1'b0, dec_raw};
    if (sub) begin
      if (!dec_raw[8]) begin
        dec_sum = {2'b00, dec_raw[7:0] + 8'ha0};
      end
    end else if (dec_raw >= 9'h0a0) begin
      dec_sum = {1'b0, dec_raw} + 10'h060;
    end

    fin   = decimal ? dec_sum : {1'b0, bin_sum};
    ov    = decimal ? (dec_raw[8] ^ dec_raw[7]) : (bin_sum[7] ^ bb[7]);
    carry = decimal ? (dec_sum[9] | dec_sum[8]) : bin_sum[8];
    if (a[7] ^ bb[7]) begin
      ov = 1'b0;
    end

    res.sum                       = fin[7:0];
    res.status                    = st;
    res.status[bcdalu_pkg::ST_N]  = fin[7];
    res.status[bcdalu_pkg::ST_V]  = ov;
    res.status[bcdalu_pkg::ST_Z]  = (fin[7:0] == 8'h00);
    res.status[bcdalu_pkg::ST_C]  = carry;
  end

endmodule

// ===== hdl/bcdalu_datapath.sv =====
// ----------------------------------------------------------------------------
// bcdalu_datapath
// Width and mode selection: 8-bit step, chained 16-bit BCD, 16-bit binary.
// ----------------------------------------------------------------------------
module bcdalu_datapath (
  input  bcdalu_pkg::in_item_t  item,
  output bcdalu_pkg::out_item_t res
);

  bcdalu_pkg::step_res_t lo_res;
  bcdalu_pkg::step_res_t hi_res;

  logic [15:0] bb;
  logic [16:0] bin_sum;
  logic [15:0] word;
  logic [8:0]  st;
  logic        ov;
  logic        carry;

  bcdalu_byte_step u_lo (
    .a   (item.operand_a[7:0]),
    .b   (item.operand_b[7:0]),
    .st  (item.status_in),
    .sub (item.subtract),
    .res (lo_res)
  );

  bcdalu_byte_step u_hi (
    .a   (item.operand_a[15:8]),
    .b   (item.operand_b[15:8]),
    .st  (lo_res.status),
    .sub (item.subtract),
    .res (hi_res)
  );

  always_comb begin
    bb      = item.subtract ? ~item.operand_b : item.operand_b;
    bin_sum = {1'b0, item.operand_a} + {1'b0, bb}
              + {16'd0, item.status_in[bcdalu_pkg::ST_C]};
    if (item.status_in[bcdalu_pkg::ST_D]) begin
      word  = {hi_res.sum, lo_res.sum};
      ov    = hi_res.status[bcdalu_pkg::ST_V];
      carry = hi_res.status[bcdalu_pkg::ST_C];
    end else begin
      word  = bin_sum[15:0];
      ov    = bin_sum[15] ^ bb[15];
      carry = bin_sum[16];
    end
    if (item.operand_a[15] ^ bb[15]) begin
      ov = 1'b0;
    end

    st                      = item.status_in;
    st[bcdalu_pkg::ST_N]    = word[15];
    st[bcdalu_pkg::ST_V]    = ov;
    st[bcdalu_pkg::ST_Z]    = (word == 16'h0000);
    st[bcdalu_pkg::ST_C]    = carry;

    if (item.wide) begin
      res.result     = word;
      res.status_out = st;
    end else begin
      res.result     = {8'h00, lo_res.sum};
      res.status_out = lo_res.status;
    end
  end

endmodule

// ===== hdl/bcd_binary_add_sub_alu_top.sv =====
// ----------------------------------------------------------------------------
// bcd_binary_add_sub_alu_top
// ADC/SBC unit: binary or BCD add and subtract, 8 or 16 bits, with flags.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with an item on in_item; it is taken at that clock edge.
//   busy is held low, so an item may be issued in every cycle.
//   Each item yields one result on out_item, marked by out_valid for
//   exactly one cycle; the receiver must take it then.
//   Each accepted item passes the input register, then the result register,
//   before its result is shown on out_item and out_valid.
//   Throughput: 1 item per cycle, set by the single combinational pass
//   between the two registers (two chained byte steps in 16-bit BCD).
//   Results leave in issue order.
//   Reset (rst_n low, synchronous) drops any item in flight and clears
//   out_valid; no result appears for a dropped item.
//   There is no back-pressure on the result side.
// ----------------------------------------------------------------------------
module bcd_binary_add_sub_alu_top (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  bcdalu_pkg::in_item_t   in_item,
  output logic                   out_valid,
  output bcdalu_pkg::out_item_t  out_item
);

  logic                  stg_vld_r;
  logic                  stg_vld_nxt;
  bcdalu_pkg::in_item_t  stg_r;
  logic                  out_vld_r;
  bcdalu_pkg::out_item_t out_r;
  bcdalu_pkg::out_item_t out_nxt;

  assign busy        = 1'b0;
  assign stg_vld_nxt = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= stg_vld_nxt;
      out_vld_r <= stg_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_vld_nxt) begin
      stg_r <= in_item;
    end
    if (stg_vld_r) begin
      out_r <= out_nxt;
    end
  end

  bcdalu_datapath u_datapath (
    .item (stg_r),
    .res  (out_nxt)
  );

  assign out_valid = out_vld_r;
  assign out_item  = out_r;

`ifndef SYNTH
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("item accepted without a result two cycles later");

  a_narrow_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_vld_r && !stg_r.wide) |=> (out_item.result[15:8] == 8'h00))
    else $error("8-bit result has non-zero upper byte");

  a_status_pass: assert property (@(posedge clk) disable iff (!rst_n)
    stg_vld_r |=> ((out_item.status_out & bcdalu_pkg::ST_PASS_MASK)
                  == ($past(stg_r.status_in) & bcdalu_pkg::ST_PASS_MASK)))
    else $error("pass-through status bits altered");

  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.status_out[bcdalu_pkg::ST_Z]
                   == (out_item.result == 16'h0000)))
    else $error("Z flag disagrees with result");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ADC/SBC unit. Directed items cover the binary
// and BCD extremes, carries, overflows and invalid digits; random items mix
// well-formed BCD operands with raw values. Each result is compared with an
// in-bench prediction, in issue order, while the sender idles in bursts.
// ----------------------------------------------------------------------------
module tb_top;
  import bcdalu_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned RAND_ITEMS  = 780;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  out_item_t   pending_results[$];
  out_item_t   want;
  int unsigned fail_cnt    = 0;
  int unsigned sent_cnt    = 0;
  int unsigned checked_cnt = 0;
  int unsigned bcd_cnt     = 0;
  int unsigned wide_cnt    = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned burst_left  = 0;

  bcd_binary_add_sub_alu_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // one byte of add or subtract; returns {sum byte, status}
  function automatic logic [BYTE_W+STATUS_W-1:0] byte_adc(
    input logic [7:0] a, input logic [7:0] b_raw, input logic [8:0] st, input logic sub);
    logic [7:0] b;
    logic [9:0] sum;
    logic [4:0] lo;
    logic       ov;
    logic [8:0] so;
    b = sub ? ~b_raw : b_raw;
    if (!st[ST_D]) begin
      sum = {2'b00, a} + {2'b00, b} + {9'd0, st[ST_C]};
      ov  = sum[7] ^ b[7];
    end else begin
      lo = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, st[ST_C]};
      if (sub) begin
        if (lo < 5'h10) lo = {1'b0, lo[3:0] - 4'd6};
      end else begin
        if (lo >= 5'd10) lo = (lo - 5'd10) | 5'h10;
      end
      sum = {2'b00, a[7:4], 4'h0} + {2'b00, b[7:4], 4'h0} + {5'd0, lo};
      ov  = sum[8] ^ sum[7];
      if (sub) begin
        if (sum < 10'h100) sum = {2'b00, sum[7:0] + 8'ha0};
      end else begin
        if (sum >= 10'h0a0) sum = sum + 10'h060;
      end
    end
    if (a[7] ^ b[7]) ov = 1'b0;
    so       = st & ST_PASS_MASK;
    so[ST_N] = sum[7];
    so[ST_V] = ov;
    so[ST_Z] = (sum[7:0] == 8'h00);
    so[ST_C] = (sum >= 10'h100);
    return {sum[7:0], so};
  endfunction

  function automatic out_item_t alu_predict(input in_item_t it);
    out_item_t                   r;
    logic [BYTE_W+STATUS_W-1:0]  lo_step;
    logic [BYTE_W+STATUS_W-1:0]  hi_step;
    logic [15:0]                 b;
    logic [16:0]                 sum;
    logic [8:0]                  st;
    logic                        ov;
    if (!it.wide) begin
      lo_step      = byte_adc(it.operand_a[7:0], it.operand_b[7:0], it.status_in, it.subtract);
      r.result     = {8'h00, lo_step[STATUS_W +: BYTE_W]};
      r.status_out = lo_step[STATUS_W-1:0];
      return r;
    end
    b = it.subtract ? ~it.operand_b : it.operand_b;
    if (!it.status_in[ST_D]) begin
      sum = {1'b0, it.operand_a} + {1'b0, b} + {16'd0, it.status_in[ST_C]};
      ov  = sum[15] ^ b[15];
    end else begin
      lo_step = byte_adc(it.operand_a[7:0], it.operand_b[7:0], it.status_in, it.subtract);
      hi_step = byte_adc(it.operand_a[15:8], it.operand_b[15:8],
                         lo_step[STATUS_W-1:0], it.subtract);
      sum = {hi_step[ST_C], hi_step[STATUS_W +: BYTE_W], lo_step[STATUS_W +: BYTE_W]};
      ov  = hi_step[ST_V];
    end
    if (it.operand_a[15] ^ b[15]) ov = 1'b0;
    st       = it.status_in & ST_PASS_MASK;
    st[ST_N] = sum[15];
    st[ST_V] = ov;
    st[ST_Z] = (sum[15:0] == 16'h0000);
    st[ST_C] = sum[16];
    r.result     = sum[15:0];
    r.status_out = st;
    return r;
  endfunction

  function automatic in_item_t mk_item(input logic [15:0] a, input logic [15:0] b,
                                       input logic [8:0] st, input logic sub,
                                       input logic wide);
    in_item_t it;
    it.operand_a = a;
    it.operand_b = b;
    it.status_in = st;
    it.subtract  = sub;
    it.wide      = wide;
    return it;
  endfunction

  function automatic logic [15:0] rand_operand(input logic bcd);
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0: v = 16'h0000;
          1: v = 16'hffff;
          2: v = 16'h9999;
          3: v = 16'h8000;
          4: v = 16'h7fff;
          default: v = 16'h0001;
        endcase
      end
      1, 2, 3, 4, 5, 6: begin
        if (bcd) begin
          v = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
               4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
        end else begin
          v = 16'($urandom);
        end
      end
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_item(input in_item_t it);
    in_item <= it;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_cnt++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 64 : 12);
      start   <= 1'b0;
      in_item <= in_item_t'({$urandom, $urandom});
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic test_binary_directed();
    send_item(mk_item(16'h0000, 16'h0000, 9'h000, 1'b0, 1'b0));
    send_item(mk_item(16'h00ff, 16'h0001, 9'h000, 1'b0, 1'b0));
    send_item(mk_item(16'h007f, 16'h0001, 9'h134, 1'b0, 1'b0));
    send_item(mk_item(16'h0080, 16'h0001, 9'h001, 1'b1, 1'b0));
    send_item(mk_item(16'hab12, 16'hcd34, 9'h1f5, 1'b0, 1'b0));
    send_item(mk_item(16'hffff, 16'h0001, 9'h000, 1'b0, 1'b1));
    send_item(mk_item(16'h7fff, 16'h0001, 9'h100, 1'b0, 1'b1));
    send_item(mk_item(16'h8000, 16'h0001, 9'h001, 1'b1, 1'b1));
    send_item(mk_item(16'h0000, 16'h0000, 9'h000, 1'b1, 1'b1));
    send_item(mk_item(16'hffff, 16'hffff, 9'h1f7, 1'b0, 1'b1));
  endtask

  task automatic test_decimal_directed();
    send_item(mk_item(16'h0099, 16'h0001, 9'h008, 1'b0, 1'b0));
    send_item(mk_item(16'h0000, 16'h0001, 9'h009, 1'b1, 1'b0));
    send_item(mk_item(16'h0050, 16'h0050, 9'h008, 1'b0, 1'b0));
    send_item(mk_item(16'h00ff, 16'h00ff, 9'h009, 1'b0, 1'b0));
    send_item(mk_item(16'h000f, 16'h00fa, 9'h1fd, 1'b1, 1'b0));
    send_item(mk_item(16'h5579, 16'h9900, 9'h009, 1'b0, 1'b0));
    send_item(mk_item(16'h9999, 16'h0001, 9'h008, 1'b0, 1'b1));
    send_item(mk_item(16'h0000, 16'h0001, 9'h009, 1'b1, 1'b1));
    send_item(mk_item(16'h4999, 16'h5000, 9'h138, 1'b0, 1'b1));
    send_item(mk_item(16'hffff, 16'hffff, 9'h009, 1'b0, 1'b1));
    send_item(mk_item(16'h1234, 16'h5678, 9'h009, 1'b1, 1'b1));
    send_item(mk_item(16'h1234, 16'h5678, 9'h008, 1'b1, 1'b1));
    send_item(mk_item(16'h8000, 16'h0001, 9'h1ff, 1'b1, 1'b1));
  endtask

  task automatic test_random();
    in_item_t it;
    logic     bcd;
    repeat (RAND_ITEMS) begin
      it.status_in         = 9'($urandom_range(0, 511));
      bcd                  = ($urandom_range(0, 1) == 1);
      it.status_in[ST_D]   = bcd;
      it.subtract          = 1'($urandom);
      it.wide              = 1'($urandom);
      it.operand_a         = rand_operand(bcd);
      it.operand_b         = rand_operand(bcd);
      send_item(it);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: result=%h status_out=%h",
                 out_item.result, out_item.status_out);
          fail_cnt++;
        end else begin
          want = pending_results.pop_front();
          checked_cnt++;
          if (out_item.result !== want.result) begin
            $error("result: expected %h, actual %h", want.result, out_item.result);
            fail_cnt++;
          end
          if (out_item.status_out !== want.status_out) begin
            $error("status_out: expected %h, actual %h",
                   want.status_out, out_item.status_out);
            fail_cnt++;
          end
        end
      end
      if (start && !busy) begin
        pending_results.push_back(alu_predict(in_item));
        if (in_item.status_in[ST_D]) bcd_cnt++;
        if (in_item.wide) wide_cnt++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending",
               cycle_cnt, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_item <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_binary_directed();
    test_decimal_directed();
    test_random();

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("sent %0d items, checked %0d results (%0d decimal, %0d sixteen-bit)",
             sent_cnt, checked_cnt, bcd_cnt, wide_cnt);
    $display("binary and BCD add/subtract in both widths, %0d failures", fail_cnt);
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
